// ----- src/rrts_pkg.sv -----
// shared codes, defaults and controller interface types for the task scheduler
package rrts_pkg;

   // default size of the task table
   localparam int SLOTS_DEFAULT = 16;

   // command codes of an input transaction
   localparam logic [1:0] CMD_TICK   = 2'd0;
   localparam logic [1:0] CMD_CREATE = 2'd1;
   localparam logic [1:0] CMD_EXIT   = 2'd2;

   // slot state codes
   localparam logic [1:0] ST_DEAD  = 2'd0;
   localparam logic [1:0] ST_READY = 2'd1;
   localparam logic [1:0] ST_RUN   = 2'd2;

   // commands from controller to datapath
   typedef struct packed {
      logic load;
      logic search;
      logic do_create;
      logic do_exit;
      logic do_tick;
      logic finish;
   } ctrl_cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic [1:0] op;
   } ctrl_status_type;

endpackage

// ----- src/rrts_ctrl.sv -----
// sequencing state machine of the task scheduler
module rrts_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   output logic                     rsp_valid,
   input  rrts_pkg::ctrl_status_type status,
   output rrts_pkg::ctrl_cmd_type    cmd
);
   import rrts_pkg::*;

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_SEARCH = 2'd1;
   localparam logic [1:0] S_COMMIT = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       strobe_ff, strobe_in;

   // next state and command decode
   always_comb begin
      state_in  = state_ff;
      strobe_in = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_SEARCH;
            end
         end
         S_SEARCH: begin
            cmd.search = 1'b1;
            state_in   = S_COMMIT;
         end
         S_COMMIT: begin
            cmd.finish = 1'b1;
            strobe_in  = 1'b1;
            state_in   = S_IDLE;
            unique case (status.op)
               CMD_TICK:   cmd.do_tick   = 1'b1;
               CMD_CREATE: cmd.do_create = 1'b1;
               CMD_EXIT:   cmd.do_exit   = 1'b1;
               default:    ;
            endcase
         end
         default: state_in = S_IDLE;
      endcase
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = strobe_ff;

endmodule

// ----- src/rrts_datapath.sv -----
// task table, slot search and result registers of the task scheduler
module rrts_datapath #(
   parameter int SLOTS = rrts_pkg::SLOTS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  rrts_pkg::ctrl_cmd_type    cmd,
   output rrts_pkg::ctrl_status_type status,
   input  logic [1:0]                req_cmd,
   input  logic [31:0]               req_start_sp,
   input  logic [31:0]               req_current_sp,
   output logic [31:0]               rsp_new_pid,
   output logic                      rsp_switched,
   output logic [31:0]               rsp_next_sp,
   output logic [3:0]                rsp_prev_slot,
   output logic [3:0]                rsp_run_slot,
   output logic                      rsp_release_valid,
   output logic [4:0]                rsp_live_count
);
   import rrts_pkg::*;

   localparam int SW = $clog2(SLOTS);
   localparam int CW = $clog2(SLOTS + 1);

   // lowest set bit of a slot vector
   function automatic logic [SW-1:0] lowest(input logic [SLOTS-1:0] v);
      logic [SW-1:0] idx;
      idx = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (v[i]) idx = SW'(i);
      end
      return idx;
   endfunction

   // captured transaction
   logic [1:0]    op_ff;
   logic [31:0]   start_sp_ff;
   logic [31:0]   cur_sp_ff;

   // task table
   logic [1:0]    slot_state_ff [SLOTS];
   logic [1:0]    slot_state_in [SLOTS];
   logic [SLOTS-1:0] owned_ff, owned_in;
   logic [SW-1:0] run_ff, run_in;
   logic [31:0]   pid_ff, pid_in;
   logic [CW-1:0] live_ff, live_in;
   logic [31:0]   sp_mem [SLOTS];

   // search results
   logic [SW-1:0] sel_ff;
   logic          found_ff;
   logic [31:0]   rd_ff;

   // result registers
   logic [31:0]   new_pid_ff, new_pid_in;
   logic          switched_ff, switched_in;
   logic [31:0]   next_sp_ff, next_sp_in;
   logic [SW-1:0] prev_ff, prev_in;
   logic          release_ff, release_in;

   logic [SLOTS-1:0] ready_vec, dead_vec, after_vec, hi_vec, lo_vec;
   logic [SW-1:0]    free_idx, pick_idx;
   logic             free_found, pick_found;
   logic [SW+3:0]    prev_wide, run_wide;
   logic [CW+4:0]    live_wide;

   assign status.op = op_ff;

   // slot vectors for the searches
   always_comb begin
      for (int i = 0; i < SLOTS; i++) begin
         ready_vec[i] = (slot_state_ff[i] == ST_READY);
         dead_vec[i]  = (slot_state_ff[i] == ST_DEAD) && (i != 0);
         after_vec[i] = (SW'(i) > run_ff);
      end
      hi_vec = ready_vec & after_vec;
      lo_vec = ready_vec & ~after_vec;
   end

   // lowest free slot above slot 0 and round-robin pick after the running slot
   assign free_found = |dead_vec;
   assign free_idx   = lowest(dead_vec);
   assign pick_found = |ready_vec;
   assign pick_idx   = (|hi_vec) ? lowest(hi_vec) : lowest(lo_vec);

   // table update and result formation
   always_comb begin
      slot_state_in = slot_state_ff;
      owned_in      = owned_ff;
      run_in        = run_ff;
      pid_in        = pid_ff;
      live_in       = live_ff;
      new_pid_in    = '0;
      switched_in   = 1'b0;
      next_sp_in    = '0;
      prev_in       = '0;
      release_in    = 1'b0;
      if (cmd.do_create && found_ff) begin
         slot_state_in[sel_ff] = ST_READY;
         owned_in[sel_ff]      = 1'b1;
         new_pid_in            = pid_ff;
         pid_in                = pid_ff + 32'd1;
         live_in               = live_ff + CW'(1);
      end
      if (cmd.do_exit) begin
         if (slot_state_ff[run_ff] != ST_DEAD) live_in = live_ff - CW'(1);
         slot_state_in[run_ff] = ST_DEAD;
      end
      if (cmd.do_tick && found_ff) begin
         if (slot_state_ff[run_ff] == ST_DEAD && owned_ff[run_ff]) begin
            release_in       = 1'b1;
            owned_in[run_ff] = 1'b0;
         end
         if (slot_state_ff[run_ff] == ST_RUN) slot_state_in[run_ff] = ST_READY;
         slot_state_in[sel_ff] = ST_RUN;
         switched_in           = 1'b1;
         // picking the running slot again reads back the pointer just saved
         next_sp_in            = (sel_ff == run_ff) ? cur_sp_ff : rd_ff;
         prev_in               = run_ff;
         run_in                = sel_ff;
      end
   end

   // transaction capture and search registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff       <= req_cmd;
         start_sp_ff <= req_start_sp;
         cur_sp_ff   <= req_current_sp;
      end
      if (cmd.search) begin
         sel_ff   <= (op_ff == CMD_CREATE) ? free_idx : pick_idx;
         found_ff <= (op_ff == CMD_CREATE) ? free_found : pick_found;
      end
   end

   // saved stack pointer memory
   always_ff @(posedge clock) begin
      if (cmd.search) rd_ff <= sp_mem[pick_idx];
      if (cmd.do_create && found_ff) sp_mem[sel_ff] <= start_sp_ff;
      else if (cmd.do_tick && found_ff) sp_mem[run_ff] <= cur_sp_ff;
   end

   // table control state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) slot_state_ff[i] <= (i == 0) ? ST_RUN : ST_DEAD;
         owned_ff <= '0;
         run_ff   <= '0;
         pid_ff   <= 32'd2;
         live_ff  <= CW'(1);
      end else begin
         slot_state_ff <= slot_state_in;
         owned_ff      <= owned_in;
         run_ff        <= run_in;
         pid_ff        <= pid_in;
         live_ff       <= live_in;
      end
   end

   // result registers
   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         new_pid_ff  <= new_pid_in;
         switched_ff <= switched_in;
         next_sp_ff  <= next_sp_in;
         prev_ff     <= prev_in;
         release_ff  <= release_in;
      end
   end

   // fit slot numbers and count to the result field widths
   assign prev_wide = {4'd0, prev_ff};
   assign run_wide  = {4'd0, run_ff};
   assign live_wide = {5'd0, live_ff};

   assign rsp_new_pid       = new_pid_ff;
   assign rsp_switched      = switched_ff;
   assign rsp_next_sp       = next_sp_ff;
   assign rsp_prev_slot     = prev_wide[3:0];
   assign rsp_run_slot      = run_wide[3:0];
   assign rsp_release_valid = release_ff;
   assign rsp_live_count    = live_wide[4:0];

endmodule

// ----- src/round_robin_task_scheduler.sv -----
// top level of the round-robin task scheduler
// A command is taken when start is high while busy is low; busy then stays high through
// the slot search with stack pointer read and the table update. The result is registered
// at the end of the update and shows for exactly one cycle with rsp_valid high. The
// receiver cannot stall, so the result must be taken in that cycle. busy is already low
// while the result shows, so a new command can already be taken. The run slot and live
// count ports are the outputs after the command has taken effect.
module round_robin_task_scheduler #(
   parameter int SLOTS = rrts_pkg::SLOTS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_cmd,
   input  logic [31:0] req_start_sp,
   input  logic [31:0] req_current_sp,
   output logic        rsp_valid,
   output logic [31:0] rsp_new_pid,
   output logic        rsp_switched,
   output logic [31:0] rsp_next_sp,
   output logic [3:0]  rsp_prev_slot,
   output logic [3:0]  rsp_run_slot,
   output logic        rsp_release_valid,
   output logic [4:0]  rsp_live_count
);
   import rrts_pkg::*;

   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   // sequencer
   rrts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .status    (status),
      .cmd       (cmd)
   );

   // task table and result path
   rrts_datapath #(
      .SLOTS (SLOTS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_cmd           (req_cmd),
      .req_start_sp      (req_start_sp),
      .req_current_sp    (req_current_sp),
      .rsp_new_pid       (rsp_new_pid),
      .rsp_switched      (rsp_switched),
      .rsp_next_sp       (rsp_next_sp),
      .rsp_prev_slot     (rsp_prev_slot),
      .rsp_run_slot      (rsp_run_slot),
      .rsp_release_valid (rsp_release_valid),
      .rsp_live_count    (rsp_live_count)
   );

endmodule
